>>> src/hfge_pkg.sv
`default_nettype none
package hfge_pkg;

	// field and state widths fixed by the block definition
	localparam int FADE_LEN_W  = 20;
	localparam int LEVEL_W     = 18;
	localparam int CNT_W       = 21;
	localparam int FADE_W      = 17;
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 1;
	localparam int CHANNELS    = 2;

	localparam logic [FADE_W-1:0]  FADE_UNITY  = 17'd65536;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 18'd65536;

	typedef enum logic [1:0] {
		OP_FRAME    = 2'd0,
		OP_FADE_IN  = 2'd1,
		OP_FADE_OUT = 2'd2
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FADE_SAMPLES = 1'b0,
		CFG_LEVEL_GAIN   = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_MIRROR,
		ST_IDX,
		ST_LOAD,
		ST_DIV,
		ST_ROM,
		ST_GAIN,
		ST_GAIN_RND,
		ST_MUL_A,
		ST_MUL_B,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

>>> src/hfge_if.sv
`default_nettype none
interface hfge_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic signed [SAMPLE_BITS-1:0] sample_a;
	logic signed [SAMPLE_BITS-1:0] sample_b;

	modport source (output valid, operation, sample_a, sample_b, input ready);
	modport sink (input valid, operation, sample_a, sample_b, output ready);
endinterface

interface hfge_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] scaled_a;
	logic signed [SAMPLE_BITS-1:0] scaled_b;
	logic                          fade_in_done;
	logic                          fade_out_done;

	modport source (output valid, scaled_a, scaled_b, fade_in_done, fade_out_done,
		input ready);
	modport sink (input valid, scaled_a, scaled_b, fade_in_done, fade_out_done,
		output ready);
endinterface
`default_nettype wire

>>> src/hfge_rom.sv
`default_nettype none
module hfge_rom import hfge_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic [$clog2(DEPTH+1)-1:0]   addr,
	output logic      [FADE_W-1:0]            rd_data
);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// quarter-wave sin^2 of position k in Q16, sine by Q30 series
	function automatic logic [FADE_W-1:0] sin2_entry(input int k);
		logic        [63:0] t;
		logic        [63:0] t2;
		logic        [63:0] term;
		logic        [63:0] sq;
		logic        [63:0] v;
		logic signed [63:0] sum;
		t    = (HALF_PI_Q30 * 64'(k) + 64'(DEPTH / 2)) / 64'(DEPTH);
		t2   = (t * t) >> 30;
		term = t;
		sum  = signed'(t);
		for (int i = 1; i <= 12; i++) begin
			// Taylor divisor (2i)(2i+1)
			term = ((term * t2) >> 30) / 64'((2 * i) * (2 * i + 1));
			if ((i & 1) != 0)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 64'sd0)
			sum = 64'sd0;
		if (sum > 64'sh4000_0000)
			sum = 64'sh4000_0000;
		sq = unsigned'(sum) * unsigned'(sum);
		v  = (sq + 64'h0000_0800_0000_0000) >> 44;
		if (v > 64'd65536)
			v = 64'd65536;
		return v[FADE_W-1:0];
	endfunction

	logic [FADE_W-1:0] fade_tab [0:DEPTH];

	for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
		localparam logic [FADE_W-1:0] ENTRY = sin2_entry(k);
		assign fade_tab[k] = ENTRY;
	end

	logic [FADE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		rd_data_q <= fade_tab[addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> src/hann_fade_gain_envelope_top.sv
`default_nettype none
// Fade and level gain for sample frames.
// in_ch carries one item per frame or fade request (operation: frame, fade in,
// fade out); out_ch returns one item per sample frame, none for requests.
// Both channels move an item when valid and ready are high at a clock edge.
// Configuration (fade_samples, level_gain) is written through cfg_wr_en /
// cfg_index / cfg_data; the user must write it only while the block is idle,
// a rule the block leaves unchecked. A new length only takes effect at the
// next fade request. A request is taken while idle and leaves ready high. A
// frame holds in_ch.ready low from acceptance through wrap, mirror, index,
// load, divide, table read, gain, gain rounding, two sample multiplies, finish
// and output; its result turns valid on the edge where ready returns, and only
// then is the next frame taken. The restoring divider forms the table index
// one quotient bit a cycle (31 bits); a zero half window skips the table steps.
// All multiplies go through one shared 19-bit by MUL_A_W-bit multiplier (sample width, at least 21).
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following frame holds in its last step
// until the register frees up.
// Reset (arst_n low, asynchronous) clears the fade state and flags, sets
// fade_samples to 0 and level_gain to 1.0, and empties the output register.
module hann_fade_gain_envelope_top import hfge_pkg::*; #(
	parameter int SAMPLE_BITS      = 24,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	hfge_in_if.sink                     in_ch,
	hfge_out_if.source                  out_ch
);

	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int NUM_W   = FADE_LEN_W + IDX_W;     // m*D + L/2
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int MUL_A_W = (SAMPLE_BITS > FADE_LEN_W + 1) ? SAMPLE_BITS : FADE_LEN_W + 1;
	localparam int MUL_B_W = LEVEL_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int RND_W   = PROD_W - 16;

	localparam logic signed [RND_W-1:0] SAT_MAX =
		RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_MIN =
		RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// round half away from zero, drop 16 fraction bits, saturate
	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
		input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] biased;
		logic signed [RND_W-1:0]  r;
		biased = p + (p[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
		r      = signed'(biased[PROD_W-1:16]);
		if (r > SAT_MAX)
			return SAT_MAX[SAMPLE_BITS-1:0];
		else if (r < SAT_MIN)
			return SAT_MIN[SAMPLE_BITS-1:0];
		else
			return r[SAMPLE_BITS-1:0];
	endfunction

	// control state
	state_t                 st_q, st_d;
	logic [FADE_LEN_W-1:0]  fs_q;
	logic [LEVEL_W-1:0]     lvl_q;
	logic [FADE_LEN_W-1:0]  half_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   in_flag_q;
	logic                   out_flag_q;
	logic                   out_valid_q;

	// working registers
	logic [CNT_W-1:0]              n_q;
	logic [FADE_LEN_W-1:0]         m_q;
	logic                          done_in_q;
	logic                          done_out_q;
	logic signed [SAMPLE_BITS-1:0] samp_a_q;
	logic signed [SAMPLE_BITS-1:0] samp_b_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic [NUM_W-1:0]              num_q;
	logic [FADE_LEN_W-1:0]         rem_q;
	logic [DCNT_W-1:0]             div_cnt_q;
	logic [LEVEL_W-1:0]            gain_q;
	logic signed [SAMPLE_BITS-1:0] res_a_q;
	logic signed [SAMPLE_BITS-1:0] res_b_q;
	logic signed [SAMPLE_BITS-1:0] out_a_q;
	logic signed [SAMPLE_BITS-1:0] out_b_q;
	logic                          out_in_done_q;
	logic                          out_out_done_q;

	// combinational
	logic                         accept_in;
	logic                         is_frame;
	logic                         in_rdy;
	logic                         out_free;
	logic                         out_load;
	logic [CNT_W-1:0]             two_l;
	logic                         hit_in;
	logic                         hit_out;
	logic                         in_flag_nxt;
	logic                         out_flag_nxt;
	logic [CNT_W-1:0]             mirror_d;
	logic [FADE_LEN_W:0]          rem_shift;
	logic                         rem_ge;
	logic [FADE_LEN_W:0]          rem_sub;
	logic [35:0]                  gain_rnd;
	logic [IDX_W-1:0]             rom_addr;
	logic [FADE_W-1:0]            rom_data;
	logic [FADE_W-1:0]            fade_sel;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]     prod_d;

	assign accept_in = in_ch.valid & in_rdy;
	assign is_frame  = (in_ch.operation == OP_FRAME);
	assign out_free  = ~out_valid_q | out_ch.ready;

	// completion checks use the counter before this frame advances it
	assign two_l        = {half_q, 1'b0};
	assign hit_in       = in_flag_q && (cnt_q == {1'b0, half_q});
	assign hit_out      = out_flag_q && (cnt_q == two_l);
	assign in_flag_nxt  = in_flag_q & ~hit_in;
	assign out_flag_nxt = out_flag_q & ~hit_out;

	assign mirror_d = two_l - n_q;

	// restoring divider step: (m*D + L/2) / L, one quotient bit a cycle
	assign rem_shift = {rem_q, num_q[NUM_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, half_q});
	assign rem_sub   = rem_shift - {1'b0, half_q};

	assign gain_rnd = prod_q[35:0] + 36'd32768;

	assign rom_addr = (num_q > NUM_W'(SINE_TABLE_DEPTH)) ?
		IDX_W'(SINE_TABLE_DEPTH) : num_q[IDX_W-1:0];

	hfge_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	assign fade_sel = (half_q == '0) ? FADE_UNITY : rom_data;

	// shared multiplier
	assign prod_d = mul_a * mul_b;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (accept_in && is_frame)
					st_d = (half_q == '0) ? ST_GAIN : ST_WRAP;
			end
			ST_WRAP:     st_d = ST_MIRROR;
			ST_MIRROR:   st_d = ST_IDX;
			ST_IDX:      st_d = ST_LOAD;
			ST_LOAD:     st_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == '0)
					st_d = ST_ROM;
			end
			ST_ROM:      st_d = ST_GAIN;
			ST_GAIN:     st_d = ST_GAIN_RND;
			ST_GAIN_RND: st_d = ST_MUL_A;
			ST_MUL_A:    st_d = ST_MUL_B;
			ST_MUL_B:    st_d = ST_FIN;
			ST_FIN:      st_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					st_d = ST_IDLE;
			end
			default:     st_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operands
	always_comb begin
		in_rdy   = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (st_q)
			ST_IDLE: in_rdy = 1'b1;
			ST_IDX: begin
				mul_a = MUL_A_W'(m_q);
				mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
			end
			ST_GAIN: begin
				mul_a = MUL_A_W'(fade_sel);
				mul_b = MUL_B_W'(lvl_q);
			end
			ST_MUL_A: begin
				mul_a = MUL_A_W'(samp_a_q);
				mul_b = MUL_B_W'(gain_q);
			end
			ST_MUL_B: begin
				mul_a = MUL_A_W'(samp_b_q);
				mul_b = MUL_B_W'(gain_q);
			end
			ST_OUT: out_load = out_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			fs_q        <= '0;
			lvl_q       <= LEVEL_RESET;
			half_q      <= '0;
			cnt_q       <= '0;
			in_flag_q   <= 1'b0;
			out_flag_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;

			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FADE_SAMPLES: fs_q  <= cfg_data[FADE_LEN_W-1:0];
					CFG_LEVEL_GAIN:   lvl_q <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end

			if (accept_in) begin
				case (in_ch.operation)
					OP_FRAME: begin
						in_flag_q  <= in_flag_nxt;
						out_flag_q <= out_flag_nxt;
						if (in_flag_nxt || out_flag_nxt)
							cnt_q <= cnt_q + 1'b1;
					end
					OP_FADE_IN: begin
						half_q    <= fs_q;
						cnt_q     <= '0;
						in_flag_q <= 1'b1;
					end
					OP_FADE_OUT: begin
						half_q     <= fs_q;
						cnt_q      <= {1'b0, fs_q};
						out_flag_q <= 1'b1;
					end
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept_in && is_frame) begin
			n_q        <= cnt_q;
			done_in_q  <= hit_in;
			done_out_q <= hit_out;
			samp_a_q   <= in_ch.sample_a;
			samp_b_q   <= in_ch.sample_b;
		end

		case (st_q)
			// counter taken modulo 2L; it stays below 4L
			ST_WRAP: begin
				if (n_q >= two_l)
					n_q <= n_q - two_l;
			end
			// fold the falling half onto the rising half
			ST_MIRROR: begin
				m_q <= (n_q <= {1'b0, half_q}) ? n_q[FADE_LEN_W-1:0] :
					mirror_d[FADE_LEN_W-1:0];
			end
			ST_LOAD: begin
				num_q     <= prod_q[NUM_W-1:0] + NUM_W'(half_q >> 1);
				rem_q     <= '0;
				div_cnt_q <= DCNT_W'(NUM_W - 1);
			end
			ST_DIV: begin
				rem_q     <= rem_ge ? rem_sub[FADE_LEN_W-1:0] :
					rem_shift[FADE_LEN_W-1:0];
				num_q     <= {num_q[NUM_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			ST_GAIN_RND: gain_q <= gain_rnd[33:16];
			ST_MUL_B:    res_a_q <= round_sat(prod_q);
			ST_FIN:      res_b_q <= (CHANNELS >= 2) ? round_sat(prod_q) : '0;
			default: ;
		endcase

		if (st_q == ST_IDX || st_q == ST_GAIN || st_q == ST_MUL_A || st_q == ST_MUL_B)
			prod_q <= prod_d;

		if (out_load) begin
			out_a_q        <= res_a_q;
			out_b_q        <= res_b_q;
			out_in_done_q  <= done_in_q;
			out_out_done_q <= done_out_q;
		end
	end

	assign in_ch.ready          = in_rdy;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.scaled_a      = out_a_q;
	assign out_ch.scaled_b      = out_b_q;
	assign out_ch.fade_in_done  = out_in_done_q;
	assign out_ch.fade_out_done = out_out_done_q;

	// a frame occupies the sequencer: no second item on the next edge
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.operation == OP_FRAME) |=> !in_ch.ready)
		else $error("item accepted while a frame is in progress");

	// fade position never runs past the end of the window
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= {half_q, 1'b0})
		else $error("fade counter beyond two half windows");

	// divider result is a legal table index
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROM) |-> (num_q <= NUM_W'(SINE_TABLE_DEPTH)))
		else $error("table index out of range");

endmodule
`default_nettype wire
